FILE: rtl/core/b64enc_pkg.sv
// shared types, constants and character lookup for the base64 stream encoder
`default_nettype none

package b64enc_pkg;

   // depth of the group queue between front and back
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   // padding character
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // how many '=' characters close a group
   typedef enum logic [1:0] {
      PAD_NONE = 2'd0,
      PAD_ONE  = 2'd1,
      PAD_TWO  = 2'd2
   } pad_type;

   // one gathered group on its way to the back end
   typedef struct packed {
      logic [23:0] bits;
      pad_type     pad;
      logic        last;
   } group_type;

   // queue status seen by the front and back ends
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // six-bit value to ASCII character of the standard alphabet
   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] code;
      code = {2'b00, idx};
      case (idx) inside
         [6'd0:6'd25]:  b64_char = 8'h41 + code;
         [6'd26:6'd51]: b64_char = 8'h61 + (code - 8'd26);
         [6'd52:6'd61]: b64_char = 8'h30 + (code - 8'd52);
         6'd62:         b64_char = 8'h2B;
         default:       b64_char = 8'h2F;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64enc_front.sv
// front end: gathers request bytes into 24-bit groups and marks padding
`default_nettype none

module b64enc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,
   input  wire b64enc_pkg::qstat_type  qstat,
   output logic                        push,
   output b64enc_pkg::group_type       push_group
);

   logic [15:0] bytes_ff, bytes_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        take;

   // stall only on a full queue
   assign req_ready = !qstat.full;
   assign take      = req_valid && req_ready;

   // pending bytes and group assembly
   always_comb begin
      bytes_in        = bytes_ff;
      cnt_in          = cnt_ff;
      push            = 1'b0;
      push_group.bits = 24'h000000;
      push_group.pad  = b64enc_pkg::PAD_NONE;
      push_group.last = 1'b0;
      if (take) begin
         case (cnt_ff)
            2'd1: begin
               if (req_last_byte) begin
                  push            = 1'b1;
                  push_group.bits = {bytes_ff[15:8], req_data_byte, 8'h00};
                  push_group.pad  = b64enc_pkg::PAD_ONE;
                  push_group.last = 1'b1;
                  bytes_in        = 16'h0000;
                  cnt_in          = 2'd0;
               end else begin
                  bytes_in = {bytes_ff[15:8], req_data_byte};
                  cnt_in   = 2'd2;
               end
            end
            2'd2: begin
               push            = 1'b1;
               push_group.bits = {bytes_ff, req_data_byte};
               push_group.pad  = b64enc_pkg::PAD_NONE;
               push_group.last = req_last_byte;
               bytes_in        = 16'h0000;
               cnt_in          = 2'd0;
            end
            default: begin
               // empty group, and the unused count value
               if (req_last_byte) begin
                  push            = 1'b1;
                  push_group.bits = {req_data_byte, 16'h0000};
                  push_group.pad  = b64enc_pkg::PAD_TWO;
                  push_group.last = 1'b1;
                  bytes_in        = 16'h0000;
                  cnt_in          = 2'd0;
               end else begin
                  bytes_in = {req_data_byte, 8'h00};
                  cnt_in   = 2'd1;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= 16'h0000;
         cnt_ff   <= 2'd0;
      end else begin
         bytes_ff <= bytes_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/b64enc_queue.sv
// short group queue between the front and back ends
`default_nettype none

module b64enc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire b64enc_pkg::group_type  push_group,
   input  wire logic                   pop,
   output b64enc_pkg::group_type       head_group,
   output b64enc_pkg::qstat_type       qstat
);

   localparam logic [b64enc_pkg::QPTR_W-1:0] PTR_LAST =
      b64enc_pkg::QPTR_W'(b64enc_pkg::QDEPTH - 1);
   localparam logic [b64enc_pkg::QCNT_W-1:0] CNT_FULL =
      b64enc_pkg::QCNT_W'(b64enc_pkg::QDEPTH);

   b64enc_pkg::group_type slot_ff [b64enc_pkg::QDEPTH];
   logic [b64enc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b64enc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b64enc_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign qstat.full  = (cnt_ff == CNT_FULL);
   assign qstat.empty = (cnt_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_group  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/b64enc_back.sv
// back end: maps a queued group to four characters in the response register
`default_nettype none

module b64enc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire b64enc_pkg::group_type  head_group,
   input  wire b64enc_pkg::qstat_type  qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_char_first,
   output logic [7:0]                  rsp_char_second,
   output logic [7:0]                  rsp_char_third,
   output logic [7:0]                  rsp_char_fourth,
   output logic                        rsp_group_last
);

   logic       valid_ff, valid_in;
   logic [7:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [7:0] c0_in, c1_in, c2_in, c3_in;
   logic       last_ff;

   // load when the response register is free or being taken
   assign pop = !qstat.empty && (!valid_ff || rsp_ready);

   // character lookup with padding
   always_comb begin
      c0_in = b64enc_pkg::b64_char(head_group.bits[23:18]);
      c1_in = b64enc_pkg::b64_char(head_group.bits[17:12]);
      c2_in = (head_group.pad == b64enc_pkg::PAD_TWO) ? b64enc_pkg::PAD_CHAR
              : b64enc_pkg::b64_char(head_group.bits[11:6]);
      c3_in = (head_group.pad == b64enc_pkg::PAD_NONE)
              ? b64enc_pkg::b64_char(head_group.bits[5:0]) : b64enc_pkg::PAD_CHAR;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         c3_ff   <= c3_in;
         last_ff <= head_group.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_first  = c0_ff;
   assign rsp_char_second = c1_ff;
   assign rsp_char_third  = c2_ff;
   assign rsp_char_fourth = c3_ff;
   assign rsp_group_last  = last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_encoder_core.sv
// top level of the base64 stream encoder
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_data_byte[7:0], req_last_byte
// rsp      out  rsp_valid/rsp_ready    rsp_char_first..rsp_char_fourth[7:0], rsp_group_last
//
// one request byte is taken every cycle while the group queue has room
// a group closed by its last byte is written to the group queue and from there loaded into the response register
// the two-entry group queue and the response register decouple the sides,
// so the request side stalls only when both are occupied
// synchronous active-high reset empties pending bytes, queue and response
`default_nettype none

module base64_stream_encoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_first,
   output logic [7:0]      rsp_char_second,
   output logic [7:0]      rsp_char_third,
   output logic [7:0]      rsp_char_fourth,
   output logic            rsp_group_last
);

   b64enc_pkg::group_type push_group;
   b64enc_pkg::group_type head_group;
   b64enc_pkg::qstat_type qstat;
   logic                  push;
   logic                  pop;

   // byte gathering
   b64enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .qstat         (qstat),
      .push          (push),
      .push_group    (push_group)
   );

   // group queue
   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .qstat      (qstat)
   );

   // character mapping and response register
   b64enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_group      (head_group),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_first  (rsp_char_first),
      .rsp_char_second (rsp_char_second),
      .rsp_char_third  (rsp_char_third),
      .rsp_char_fourth (rsp_char_fourth),
      .rsp_group_last  (rsp_group_last)
   );

endmodule

`default_nettype wire
